>>> sv/nssf_pkg.sv
package nssf_pkg;

	localparam int NUM_POS = 4;
	localparam int VALUE_W = 16;
	localparam int DIG_W   = 4;
	localparam int CNT_W   = 3;
	localparam int SEG_W   = 7;

	// display mode codes
	localparam logic MODE_DEC = 1'b0;
	localparam logic MODE_HEX = 1'b1;

	// segment patterns, bit0 = A .. bit6 = G
	localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;
	localparam logic [SEG_W-1:0] SEG_ZERO  = 7'h3F;
	localparam logic [SEG_W-1:0] SEG_MINUS = 7'h40;

	typedef logic [SEG_W-1:0] seg_t;

	// digits of one value, digit 0 is the rightmost
	typedef struct packed {
		logic [NUM_POS-1:0][DIG_W-1:0] dig;
		logic [CNT_W-1:0]              cnt;  // significant digits, 1..NUM_POS
		logic                          neg;  // negative decimal value
	} digits_t;

	function automatic seg_t glyph(input logic [DIG_W-1:0] d);
		seg_t s;
		unique case (d)
			4'h0: s = 7'h3F;
			4'h1: s = 7'h06;
			4'h2: s = 7'h5B;
			4'h3: s = 7'h4F;
			4'h4: s = 7'h66;
			4'h5: s = 7'h6D;
			4'h6: s = 7'h7D;
			4'h7: s = 7'h07;
			4'h8: s = 7'h7F;
			4'h9: s = 7'h6F;
			4'hA: s = 7'h77;
			4'hB: s = 7'h7C;
			4'hC: s = 7'h39;
			4'hD: s = 7'h5E;
			4'hE: s = 7'h79;
			default: s = 7'h71;
		endcase
		return s;
	endfunction

endpackage

>>> sv/nssf_conv.sv
module nssf_conv (
	input  logic [nssf_pkg::VALUE_W-1:0] value,
	input  logic                         mode,
	output nssf_pkg::digits_t            digits
);
	import nssf_pkg::*;

	logic                neg;
	logic [VALUE_W-1:0]  mag;
	logic [31:0]         p1;
	logic [31:0]         p2;
	logic [32:0]         p3;
	logic [30:0]         p4;
	logic [11:0]         q1;   // mag / 10
	logic [8:0]          q2;   // mag / 100
	logic [5:0]          q3;   // mag / 1000
	logic [1:0]          q4;   // mag / 10000
	logic [NUM_POS-1:0][DIG_W-1:0] dec_dig;
	logic [CNT_W-1:0]    dec_cnt;
	logic [CNT_W-1:0]    hex_cnt;

	// magnitude fits 16 bits unsigned, -32768 gives 32768
	assign neg = (mode == MODE_DEC) && value[VALUE_W-1];
	assign mag = neg ? (~value + 16'd1) : value;

	// reciprocal constants, exact for mag <= 32768
	assign p1 = 32'(mag) * 32'd52429;
	assign p2 = 32'(mag) * 32'd5243;
	assign p3 = 33'(mag) * 33'd67109;
	assign p4 = 31'(mag) * 31'd26844;

	assign q1 = p1[30:19];
	assign q2 = p2[27:19];
	assign q3 = p3[31:26];
	assign q4 = p4[29:28];

	assign dec_dig[0] = DIG_W'(mag - 16'(q1) * 16'd10);
	assign dec_dig[1] = DIG_W'(q1 - 12'(q2) * 12'd10);
	assign dec_dig[2] = DIG_W'(q2 - 9'(q3) * 9'd10);
	assign dec_dig[3] = DIG_W'(q3 - 6'(q4) * 6'd10);

	always_comb begin
		if (q3 != '0)      dec_cnt = 3'd4;
		else if (q2 != '0) dec_cnt = 3'd3;
		else if (q1 != '0) dec_cnt = 3'd2;
		else               dec_cnt = 3'd1;
	end

	always_comb begin
		if (value[15:12] != '0)     hex_cnt = 3'd4;
		else if (value[11:8] != '0) hex_cnt = 3'd3;
		else if (value[7:4] != '0)  hex_cnt = 3'd2;
		else                        hex_cnt = 3'd1;
	end

	always_comb begin
		digits.neg = neg;
		if (mode == MODE_HEX) begin
			digits.dig = value;
			digits.cnt = hex_cnt;
		end else begin
			digits.dig = dec_dig;
			digits.cnt = dec_cnt;
		end
	end

endmodule

>>> sv/nssf_fmt.sv
module nssf_fmt (
	input  nssf_pkg::digits_t                           digits,
	input  logic                                        zero_fill,
	output logic [nssf_pkg::NUM_POS-1:0][nssf_pkg::SEG_W-1:0] seg
);
	import nssf_pkg::*;

	// seg[0] is the leftmost position
	for (genvar i = 0; i < NUM_POS; i++) begin : g_pos
		localparam logic [CNT_W-1:0] K = CNT_W'(NUM_POS - 1 - i);
		always_comb begin
			if (K < digits.cnt)                   seg[i] = glyph(digits.dig[NUM_POS-1-i]);
			else if (zero_fill)                   seg[i] = SEG_ZERO;
			else if (digits.neg && K == digits.cnt) seg[i] = SEG_MINUS;
			else                                  seg[i] = SEG_BLANK;
		end
	end

endmodule

>>> sv/number_to_seven_segment_formatter.sv
// Number to seven-segment formatter.
// Input channel (in_valid / in_stall) carries value, mode and zero_fill;
// output channel (out_valid / out_stall) carries four segment patterns,
// seg_pos0 leftmost .. seg_pos3 rightmost, bit0 = A .. bit6 = G.
// A transfer happens on a rising edge with valid high and stall low.
// The accepted item lands in the input register at the transfer edge; digit
// extraction and formatting run in one pass of logic and the result register
// loads once it can advance, raising out_valid. Throughput: one item per
// cycle while out_stall is low, set by the two-register pipeline.
// Decimal digits come from parallel constant reciprocal products, so no
// divider or iterative loop sits in the path.
// Reset (arst_n low) empties both stages; out_valid drops at once.
// When the receiver stalls, the result register holds its patterns; the input
// register keeps filling, and in_stall rises only once both stages are full.
// in_stall is a combinational function of out_stall and the stage valids.
module number_to_seven_segment_formatter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [nssf_pkg::VALUE_W-1:0] value,
	input  logic                         mode,
	input  logic                         zero_fill,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [nssf_pkg::SEG_W-1:0]   seg_pos0,
	output logic [nssf_pkg::SEG_W-1:0]   seg_pos1,
	output logic [nssf_pkg::SEG_W-1:0]   seg_pos2,
	output logic [nssf_pkg::SEG_W-1:0]   seg_pos3
);
	import nssf_pkg::*;

	// input stage
	logic                 valid_s1;
	logic [VALUE_W-1:0]   value_s1;
	logic                 mode_s1;
	logic                 lz_s1;

	// result stage
	logic                 valid_s2;
	logic [NUM_POS-1:0][SEG_W-1:0] seg_s2;

	logic                 adv_s1;
	logic                 adv_s2;
	digits_t              digits;
	logic [NUM_POS-1:0][SEG_W-1:0] seg_c;

	// a stage moves when it is empty or the stage after it moves
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			value_s1 <= value;
			mode_s1  <= mode;
			lz_s1    <= zero_fill;
		end
	end

	nssf_conv u_conv (
		.value  (value_s1),
		.mode   (mode_s1),
		.digits (digits)
	);

	nssf_fmt u_fmt (
		.digits    (digits),
		.zero_fill (lz_s1),
		.seg       (seg_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			seg_s2 <= seg_c;
		end
	end

	assign out_valid = valid_s2;
	assign seg_pos0  = seg_s2[0];
	assign seg_pos1  = seg_s2[1];
	assign seg_pos2  = seg_s2[2];
	assign seg_pos3  = seg_s2[3];

	// an empty input stage never pushes back
	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("in_stall raised with empty input stage");

	// an accepted transfer lands in the input stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted item lost at input stage");

	// a held item is kept while the output is stalled
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && out_stall) |=> (valid_s1 && valid_s2))
		else $error("item dropped under output stall");

	// a pending item follows a delivered result
	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !out_stall) |=> valid_s2)
		else $error("pending item not moved to result stage");

endmodule

>>> test/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import nssf_pkg::*;

	// One number offered to the formatter. A hold entry carries no number: the
	// sender stops there until every pattern already in flight has come back.
	typedef struct {
		logic [VALUE_W-1:0] value;
		logic               mode;
		logic               lz;
		bit                 hold;
	} number_t;

	// Four positions, index 0 is the leftmost one (seg_pos0).
	typedef logic [NUM_POS-1:0][SEG_W-1:0] digits_shown_t;

	typedef struct {
		number_t       src;
		digits_shown_t segs;
	} shown_t;

	// Digit glyphs 0..F packed into one vector, digit 0 in the low bits.
	localparam logic [16*SEG_W-1:0] FONT = {
		7'h71, 7'h79, 7'h5E, 7'h39, 7'h7C, 7'h77, 7'h6F, 7'h7F,
		7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
	};

	// Cycles without any transfer on either channel before the run is abandoned.
	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 600;
	// Long receiver hold-off, long enough to back the block up into in_stall.
	localparam int HOLD_OFF     = 80;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_stall;
	logic [VALUE_W-1:0]   value        = '0;
	logic                 mode         = MODE_DEC;
	logic                 zero_fill    = 1'b0;
	logic                 out_valid;
	logic                 out_stall    = 1'b0;
	logic [SEG_W-1:0]     seg_pos0;
	logic [SEG_W-1:0]     seg_pos1;
	logic [SEG_W-1:0]     seg_pos2;
	logic [SEG_W-1:0]     seg_pos3;

	number_t pending_numbers[$];
	shown_t  expected_patterns[$];

	// sender state
	number_t cur_number;
	int      tx_gap     = 0;
	bit      tx_burst   = 1'b0;
	bit      tx_paused  = 1'b0;

	// receiver state
	int      rx_gap     = 0;
	int      rx_hold    = 0;
	int      rx_count   = 0;
	bit      rx_burst   = 1'b0;
	int      rx_pick;

	int      mismatches = 0;
	int      idle_cycles = 0;
	digits_shown_t got_segs;
	shown_t        exp_entry;

	always #10 clk = ~clk;

	number_to_seven_segment_formatter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.mode         (mode),
		.zero_fill    (zero_fill),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.seg_pos0     (seg_pos0),
		.seg_pos1     (seg_pos1),
		.seg_pos2     (seg_pos2),
		.seg_pos3     (seg_pos3)
	);

	// Expected patterns for one number. Digits are laid down right to left,
	// at least one and at most NUM_POS of them; leading-zero fill then covers
	// what is left on the left. A negative decimal number gets a minus just
	// left of its leftmost lit position, if any blank position is left there.
	function automatic digits_shown_t format_display(logic [VALUE_W-1:0] v, logic m, logic lz);
		digits_shown_t segs;
		logic [VALUE_W:0] mag;
		logic [3:0]       dg;
		logic             neg;
		int               base;
		int               ndig;
		int               lit;
		segs = '0;
		neg  = (m == MODE_DEC) && v[VALUE_W-1];
		// most negative value ends up as magnitude 32768
		mag  = neg ? (17'h10000 - {1'b0, v}) : {1'b0, v};
		base = (m == MODE_HEX) ? 16 : 10;
		ndig = 0;
		do begin
			dg = 4'(mag % base);
			segs[NUM_POS-1-ndig] = FONT[dg*SEG_W +: SEG_W];
			mag = 17'(mag / base);
			ndig++;
		end while (mag != 0 && ndig < NUM_POS);
		if (lz) begin
			for (int i = 0; i < NUM_POS - ndig; i++)
				segs[i] = SEG_ZERO;
		end
		if (neg) begin
			lit = 0;
			while (lit < NUM_POS && segs[lit] == SEG_BLANK)
				lit++;
			if (lit > 0)
				segs[lit-1] = SEG_MINUS;
		end
		return segs;
	endfunction

	// Mostly back to back, some short gaps, now and then a long one.
	function automatic int pick_gap(bit burst);
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic add_number(logic [VALUE_W-1:0] v, logic m, logic lz);
		number_t n;
		n.value = v;
		n.mode  = m;
		n.lz    = lz;
		n.hold  = 1'b0;
		pending_numbers.push_back(n);
	endtask

	task automatic add_hold();
		number_t n;
		n = '{value: '0, mode: MODE_DEC, lz: 1'b0, hold: 1'b1};
		pending_numbers.push_back(n);
	endtask

	// ---------------------------------------------------------------------
	// Sender. A transfer is taken at the edge where in_valid is high and
	// in_stall is low; the expectation is worked out right then. While
	// stalled the payload holds. Otherwise the next number is presented
	// after its random gap, unless a hold entry has paused the sender.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_patterns.push_back('{src: cur_number,
					segs: format_display(cur_number.value, cur_number.mode, cur_number.lz)});
			end
			if (!(in_valid && in_stall)) begin
				if (tx_paused && expected_patterns.size() == 0)
					tx_paused = 1'b0;
				if (tx_paused) begin
					in_valid <= 1'b0;
				end else if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (pending_numbers.size() > 0) begin
					cur_number = pending_numbers.pop_front();
					if (cur_number.hold) begin
						tx_paused = 1'b1;
						in_valid  <= 1'b0;
					end else begin
						value        <= cur_number.value;
						mode         <= cur_number.mode;
						zero_fill    <= cur_number.lz;
						in_valid     <= 1'b1;
						if ($urandom_range(0, 39) == 0)
							tx_burst = !tx_burst;
						tx_gap = pick_gap(tx_burst);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Receiver. Each result transfer is checked position by position against
	// the oldest expectation. Stall is random, with two long hold-offs that
	// let the sender run into a full pipeline.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got_segs = {seg_pos3, seg_pos2, seg_pos1, seg_pos0};
				if (expected_patterns.size() == 0) begin
					report_mismatch($sformatf("result %h %h %h %h with nothing expected",
						seg_pos0, seg_pos1, seg_pos2, seg_pos3));
				end else begin
					exp_entry = expected_patterns.pop_front();
					for (int p = 0; p < NUM_POS; p++) begin
						if (got_segs[p] !== exp_entry.segs[p])
							report_mismatch($sformatf(
								"seg_pos%0d for value %h mode %0d lz %0d: got %h, expected %h",
								p, exp_entry.src.value, exp_entry.src.mode,
								exp_entry.src.lz, got_segs[p], exp_entry.segs[p]));
					end
				end
				rx_count++;
				if (rx_count == 150 || rx_count == 450)
					rx_hold = HOLD_OFF;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				out_stall <= 1'b1;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_stall <= 1'b1;
			end else begin
				if ($urandom_range(0, 39) == 0)
					rx_burst = !rx_burst;
				rx_pick = pick_gap(rx_burst);
				out_stall <= (rx_pick != 0);
				rx_gap = (rx_pick > 0) ? rx_pick - 1 : 0;
			end
		end
	end

	// Watchdog: any transfer on either side restarts the count.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus and end of run.
	// ---------------------------------------------------------------------
	initial begin
		logic [VALUE_W-1:0] v;
		int                 kind;

		// zero in both modes, with and without leading zeros
		add_number(16'h0000, MODE_DEC, 1'b0);
		add_number(16'h0000, MODE_DEC, 1'b1);
		add_number(16'h0000, MODE_HEX, 1'b0);
		add_number(16'h0000, MODE_HEX, 1'b1);
		// all ones: -1 in decimal, FFFF in hex
		add_number(16'hFFFF, MODE_DEC, 1'b0);
		add_number(16'hFFFF, MODE_HEX, 1'b0);
		// most negative value, truncated to 2768 in decimal with no room for a minus
		add_number(16'h8000, MODE_DEC, 1'b0);
		add_number(16'h8000, MODE_DEC, 1'b1);
		add_number(16'h8000, MODE_HEX, 1'b1);
		// largest positive, five digits cut to four
		add_number(16'h7FFF, MODE_DEC, 1'b0);
		add_number(16'd9999, MODE_DEC, 1'b0);
		add_number(16'd10000, MODE_DEC, 1'b0);
		// -9999 fills all positions, -999 leaves room for the minus
		add_number(16'hD8F1, MODE_DEC, 1'b0);
		add_number(16'hFC19, MODE_DEC, 1'b0);
		// negative with leading zeros: fill wins, no minus
		add_number(16'hFFFB, MODE_DEC, 1'b1);
		add_number(16'hFFFB, MODE_DEC, 1'b0);
		add_number(16'd123, MODE_DEC, 1'b1);
		add_number(16'd1, MODE_DEC, 1'b0);
		add_number(16'h00AB, MODE_HEX, 1'b0);
		add_number(16'h00AB, MODE_HEX, 1'b1);
		add_number(16'h1234, MODE_HEX, 1'b0);
		add_number(16'hFEDC, MODE_HEX, 1'b0);
		add_number(16'h0001, MODE_HEX, 1'b1);
		add_hold();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2: v = 16'($urandom);
				3:       v = 16'($urandom_range(0, 99));
				4, 5:    v = 16'($urandom_range(0, 9999));
				6, 7:    v = 16'h0000 - 16'($urandom_range(1, 9999));
				8:       v = 16'h0000 - 16'($urandom_range(1, 99));
				default: begin
					// near the sign boundary and the ends of the range
					v = 16'($urandom_range(0, 3));
					case ($urandom_range(0, 2))
						0: v = 16'h7FFF - v;
						1: v = 16'h8000 + v;
						default: v = 16'hFFFF - v;
					endcase
				end
			endcase
			add_number(v, 1'($urandom), 1'($urandom));
			if (i == RANDOM_ITEMS / 2)
				add_hold();
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (pending_numbers.size() != 0 || in_valid || tx_paused ||
			expected_patterns.size() != 0);
		// keep running so a stray extra result would still be caught
		repeat (6) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
